// ===== design/orientation_vector_to_quaternion_macros.svh =====
// ----------------------------------------------------------------------------
// orientation vector to quaternion assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef ORIENTATION_VECTOR_TO_QUATERNION_MACROS_SVH
`define ORIENTATION_VECTOR_TO_QUATERNION_MACROS_SVH

// same-cycle implication
`define OVQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define OVQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== design/ovq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovq_pkg
// types, constants and arithmetic helpers for the orientation quaternion pipe
// ----------------------------------------------------------------------------
package ovq_pkg;

   localparam int ANGLE_ITERATIONS = 16;
   localparam int SQRT_STEPS       = 32;
   localparam int NORM_STEPS       = 6;
   localparam int STEP_W           = 5;
   localparam int PAIR_W           = 44;
   localparam int ANG_W            = 32;
   localparam int TRIG_W           = 34;
   localparam int SQ_W             = 64;
   localparam int NORM_TOP         = 40;

   localparam logic signed [ANG_W-1:0]  ANG_PI      = 32'sd843314856;
   localparam logic signed [ANG_W-1:0]  ANG_HALF_PI = 32'sd421657428;
   localparam logic signed [TRIG_W-1:0] TRIG_GAIN   = 34'sd652032874;

   typedef struct packed {
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [19:0] twist;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic               zero_dir;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec3_type;

   typedef struct packed {
      logic signed [19:0] twist;
      logic               zero;
      logic               xy_zero;
   } side_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic signed [PAIR_W-1:0] a;
      logic signed [PAIR_W-1:0] b;
      logic signed [ANG_W-1:0]  ang;
   } pair_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [ANG_W-1:0]  ang;
      logic                     neg;
   } rot_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [ANG_W-1:0] r;
      case (i)
         5'd0: r = 32'sd210828714;
         5'd1: r = 32'sd124459457;
         5'd2: r = 32'sd65760959;
         5'd3: r = 32'sd33381290;
         5'd4: r = 32'sd16755422;
         5'd5: r = 32'sd8385879;
         5'd6: r = 32'sd4193963;
         5'd7: r = 32'sd2097109;
         5'd8: r = 32'sd1048571;
         5'd9: r = 32'sd524287;
         default: begin
            if (i <= 5'd28) r = 32'sd1 <<< (5'd28 - i);
            else r = '0;
         end
      endcase
      return r;
   endfunction

   // product of two q4.30 values, rounded half up
   function automatic logic signed [TRIG_W-1:0] mulq(input logic signed [TRIG_W-1:0] a,
                                                     input logic signed [TRIG_W-1:0] b);
      logic signed [2*TRIG_W-1:0] p;
      p = a * b + $signed((2*TRIG_W)'(1) << 29);
      return p[TRIG_W+29:30];
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [TRIG_W:0] v);
      logic signed [TRIG_W:0] r;
      logic signed [15:0]     q;
      r = $signed(v + ((TRIG_W+1)'(1) << 14)) >>> 15;
      if (r > 35'sd32767) q = 16'sd32767;
      else if (r < -35'sd32768) q = -16'sd32768;
      else q = r[15:0];
      return q;
   endfunction

   // fold into +-pi/2 and seed the rotation
   function automatic rot_type rot_seed(input logic signed [ANG_W-1:0] ang);
      rot_type r;
      r.x   = TRIG_GAIN;
      r.y   = '0;
      r.neg = 1'b0;
      r.ang = ang;
      if (ang > ANG_HALF_PI) begin
         r.ang = ang - ANG_PI;
         r.neg = 1'b1;
      end else if (ang < -ANG_HALF_PI) begin
         r.ang = ang + ANG_PI;
         r.neg = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== design/orientation_vector_to_quaternion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orientation_vector_to_quaternion
// pointing vector plus twist angle to a saturated q1.15 unit quaternion
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted every cycle while the output is not
// held. The pipe is a chain of cells: squaring and sum (2), a 32-cell integer
// square root, 6 pre-scaling cells, the vectoring cordic cells, one angle fold
// stage, the rotation cordic cells and a 3-stage combine whose last register
// is the output. When a result is not taken the whole pipe holds; req_ready
// follows rsp_ready while a result waits. An all-zero vector raises zero_dir.
module orientation_vector_to_quaternion (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ovq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ovq_pkg::rsp_type  rsp_data
);

   localparam int N        = ovq_pkg::ANGLE_ITERATIONS;
   localparam int NS       = ovq_pkg::NORM_STEPS;
   localparam int QS       = ovq_pkg::SQRT_STEPS;
   localparam int XYZ_N    = 2 + QS;
   localparam int VEC_BASE = XYZ_N + NS;
   localparam int SIDE_N   = VEC_BASE + N;
   localparam int DEPTH    = VEC_BASE + 2 * N + 4;

   logic                         adv;
   logic [DEPTH-1:0]             valid_ff;
   logic signed [63:0]           x2_ff, y2_ff;
   logic [ovq_pkg::SQ_W-1:0]     n_ff;
   ovq_pkg::vec3_type            xyz_ff [XYZ_N];
   ovq_pkg::side_type            side_ff [SIDE_N];
   ovq_pkg::side_type            side_in;
   logic                         zd_ff [N+1];

   ovq_pkg::sqrt_type            sq_d [QS+1];
   ovq_pkg::pair_type            lat_d [NS+N+1];
   ovq_pkg::pair_type            lon_d [NS+N+1];
   ovq_pkg::rot_type             lonr_d [N+1];
   ovq_pkg::rot_type             latr_d [N+1];
   ovq_pkg::rot_type             twr_d [N+1];

   logic signed [ovq_pkg::ANG_W-1:0] lat_a, lon_a, tw_a;
   ovq_pkg::side_type                side_last;

   assign adv       = !valid_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[DEPTH-1];

   always_comb begin
      side_in.twist   = req_data.twist;
      side_in.xy_zero = (req_data.dir_x == '0) && (req_data.dir_y == '0);
      side_in.zero    = side_in.xy_zero && (req_data.dir_z == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
      end
   end

   // squares and sum
   always_ff @(posedge clock) begin
      if (adv) begin
         x2_ff      <= req_data.dir_x * req_data.dir_x;
         y2_ff      <= req_data.dir_y * req_data.dir_y;
         n_ff       <= $unsigned(x2_ff) + $unsigned(y2_ff);
         xyz_ff[0]  <= '{x: req_data.dir_x, y: req_data.dir_y, z: req_data.dir_z};
         side_ff[0] <= side_in;
         for (int k = 1; k < XYZ_N; k++) xyz_ff[k] <= xyz_ff[k-1];
         for (int k = 1; k < SIDE_N; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   assign sq_d[0] = '{rem: n_ff, root: '0};

   for (genvar j = 0; j < QS; j++) begin : g_sqrt
      ovq_sqrt_cell u_cell (
         .clock (clock),
         .en    (adv),
         .step  (ovq_pkg::STEP_W'(j)),
         .d_in  (sq_d[j]),
         .d_out (sq_d[j+1])
      );
   end

   assign lat_d[0] = '{a: ovq_pkg::PAIR_W'(xyz_ff[XYZ_N-1].z),
                       b: $signed({12'd0, sq_d[QS].root[31:0]}),
                       ang: '0};
   assign lon_d[0] = '{a: ovq_pkg::PAIR_W'(xyz_ff[XYZ_N-1].x),
                       b: ovq_pkg::PAIR_W'(xyz_ff[XYZ_N-1].y),
                       ang: '0};

   for (genvar j = 0; j < NS; j++) begin : g_norm
      ovq_norm_cell u_lat (
         .clock (clock), .en (adv), .step (ovq_pkg::STEP_W'(j)),
         .d_in  (lat_d[j]), .d_out (lat_d[j+1])
      );
      ovq_norm_cell u_lon (
         .clock (clock), .en (adv), .step (ovq_pkg::STEP_W'(j)),
         .d_in  (lon_d[j]), .d_out (lon_d[j+1])
      );
   end

   for (genvar j = 0; j < N; j++) begin : g_vec
      ovq_vec_cell u_lat (
         .clock (clock), .en (adv), .step (ovq_pkg::STEP_W'(j)),
         .d_in  (lat_d[NS+j]), .d_out (lat_d[NS+j+1])
      );
      ovq_vec_cell u_lon (
         .clock (clock), .en (adv), .step (ovq_pkg::STEP_W'(j)),
         .d_in  (lon_d[NS+j]), .d_out (lon_d[NS+j+1])
      );
   end

   // angle fold into rotation seeds
   assign side_last = side_ff[SIDE_N-1];

   always_comb begin
      if (side_last.zero) begin
         lat_a = ovq_pkg::ANG_HALF_PI;
         lon_a = '0;
      end else begin
         lat_a = lat_d[NS+N].ang;
         lon_a = side_last.xy_zero ? '0 : lon_d[NS+N].ang;
      end
      tw_a = ovq_pkg::ANG_W'(side_last.twist) <<< 11;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lonr_d[0] <= ovq_pkg::rot_seed(lon_a >>> 1);
         latr_d[0] <= ovq_pkg::rot_seed(lat_a >>> 1);
         twr_d[0]  <= ovq_pkg::rot_seed(tw_a);
         zd_ff[0]  <= side_last.zero;
         for (int k = 1; k <= N; k++) zd_ff[k] <= zd_ff[k-1];
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_rot
      ovq_rot_cell u_lon (
         .clock (clock), .en (adv), .step (ovq_pkg::STEP_W'(j)),
         .d_in  (lonr_d[j]), .d_out (lonr_d[j+1])
      );
      ovq_rot_cell u_lat (
         .clock (clock), .en (adv), .step (ovq_pkg::STEP_W'(j)),
         .d_in  (latr_d[j]), .d_out (latr_d[j+1])
      );
      ovq_rot_cell u_tw (
         .clock (clock), .en (adv), .step (ovq_pkg::STEP_W'(j)),
         .d_in  (twr_d[j]), .d_out (twr_d[j+1])
      );
   end

   ovq_mix u_mix (
      .clock (clock),
      .en    (adv),
      .lon   (lonr_d[N]),
      .lat   (latr_d[N]),
      .tw    (twr_d[N]),
      .zero  (zd_ff[N]),
      .d_out (rsp_data)
   );

endmodule

// ===== design/ovq_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovq_sqrt_cell
// one digit step of the integer square root
// ----------------------------------------------------------------------------
module ovq_sqrt_cell (
   input  logic                          clock,
   input  logic                          en,
   input  logic [ovq_pkg::STEP_W-1:0]    step,
   input  ovq_pkg::sqrt_type             d_in,
   output ovq_pkg::sqrt_type             d_out
);

   ovq_pkg::sqrt_type            q_in;
   ovq_pkg::sqrt_type            q_ff;
   logic [ovq_pkg::SQ_W-1:0]     one_bit;
   logic [ovq_pkg::SQ_W-1:0]     trial;

   always_comb begin
      one_bit = ovq_pkg::SQ_W'(1) << (6'd62 - {step, 1'b0});
      trial   = d_in.root + one_bit;
      if (d_in.rem >= trial) begin
         q_in.rem  = d_in.rem - trial;
         q_in.root = (d_in.root >> 1) + one_bit;
      end else begin
         q_in.rem  = d_in.rem;
         q_in.root = d_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule

// ===== design/ovq_norm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovq_norm_cell
// one binary step of the pre-scaling shift ahead of vectoring
// ----------------------------------------------------------------------------
module ovq_norm_cell (
   input  logic                          clock,
   input  logic                          en,
   input  logic [ovq_pkg::STEP_W-1:0]    step,
   input  ovq_pkg::pair_type             d_in,
   output ovq_pkg::pair_type             d_out
);

   ovq_pkg::pair_type                   q_in;
   ovq_pkg::pair_type                   q_ff;
   logic [5:0]                          sh;
   logic signed [ovq_pkg::PAIR_W-1:0]   lim;
   logic                                fits;

   always_comb begin
      sh   = 6'd32 >> step;
      lim  = ovq_pkg::PAIR_W'(1) <<< (6'(ovq_pkg::NORM_TOP) - sh);
      fits = (d_in.a < lim) && (d_in.a > -lim) && (d_in.b < lim) && (d_in.b > -lim);
      q_in = d_in;
      if (fits) begin
         q_in.a = d_in.a <<< sh;
         q_in.b = d_in.b <<< sh;
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule

// ===== design/ovq_vec_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovq_vec_cell
// one vectoring cordic iteration, first cell also folds the left half plane
// ----------------------------------------------------------------------------
module ovq_vec_cell (
   input  logic                          clock,
   input  logic                          en,
   input  logic [ovq_pkg::STEP_W-1:0]    step,
   input  ovq_pkg::pair_type             d_in,
   output ovq_pkg::pair_type             d_out
);

   ovq_pkg::pair_type   p;
   ovq_pkg::pair_type   q_in;
   ovq_pkg::pair_type   q_ff;

   always_comb begin
      p = d_in;
      if (step == '0 && d_in.a < 0) begin
         if (d_in.b >= 0) begin
            p.a   = d_in.b;
            p.b   = -d_in.a;
            p.ang = ovq_pkg::ANG_HALF_PI;
         end else begin
            p.a   = -d_in.b;
            p.b   = d_in.a;
            p.ang = -ovq_pkg::ANG_HALF_PI;
         end
      end
      if (p.b >= 0) begin
         q_in.a   = p.a + (p.b >>> step);
         q_in.b   = p.b - (p.a >>> step);
         q_in.ang = p.ang + ovq_pkg::atan_entry(step);
      end else begin
         q_in.a   = p.a - (p.b >>> step);
         q_in.b   = p.b + (p.a >>> step);
         q_in.ang = p.ang - ovq_pkg::atan_entry(step);
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule

// ===== design/ovq_rot_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovq_rot_cell
// one rotation cordic iteration toward sine and cosine
// ----------------------------------------------------------------------------
module ovq_rot_cell (
   input  logic                          clock,
   input  logic                          en,
   input  logic [ovq_pkg::STEP_W-1:0]    step,
   input  ovq_pkg::rot_type              d_in,
   output ovq_pkg::rot_type              d_out
);

   ovq_pkg::rot_type   q_in;
   ovq_pkg::rot_type   q_ff;

   always_comb begin
      q_in.neg = d_in.neg;
      if (d_in.ang >= 0) begin
         q_in.x   = d_in.x - (d_in.y >>> step);
         q_in.y   = d_in.y + (d_in.x >>> step);
         q_in.ang = d_in.ang - ovq_pkg::atan_entry(step);
      end else begin
         q_in.x   = d_in.x + (d_in.y >>> step);
         q_in.y   = d_in.y - (d_in.x >>> step);
         q_in.ang = d_in.ang + ovq_pkg::atan_entry(step);
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule

// ===== design/ovq_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovq_mix
// three-stage triple-product combine and q1.15 rounding
// ----------------------------------------------------------------------------
module ovq_mix (
   input  logic                clock,
   input  logic                en,
   input  ovq_pkg::rot_type    lon,
   input  ovq_pkg::rot_type    lat,
   input  ovq_pkg::rot_type    tw,
   input  logic                zero,
   output ovq_pkg::rsp_type    d_out
);

   localparam int W = ovq_pkg::TRIG_W;

   logic signed [W-1:0] s0, c0, s1, c1, s2, c2;
   logic signed [W-1:0] cs1_ff, ss1_ff, cc1_ff, sc1_ff, s2_ff, c2_ff;
   logic                z1_ff, z2_ff;
   logic signed [W-1:0] p_cs_s2_ff, p_ss_c2_ff, p_cs_c2_ff, p_ss_s2_ff;
   logic signed [W-1:0] p_sc_c2_ff, p_cc_s2_ff, p_cc_c2_ff, p_sc_s2_ff;
   ovq_pkg::rsp_type    out_in;
   ovq_pkg::rsp_type    out_ff;

   always_comb begin
      s0 = lon.neg ? -lon.y : lon.y;
      c0 = lon.neg ? -lon.x : lon.x;
      s1 = lat.neg ? -lat.y : lat.y;
      c1 = lat.neg ? -lat.x : lat.x;
      s2 = tw.neg  ? -tw.y  : tw.y;
      c2 = tw.neg  ? -tw.x  : tw.x;
   end

   always_comb begin
      out_in.quat_x   = ovq_pkg::to_q15((W+1)'(p_cs_s2_ff) - (W+1)'(p_ss_c2_ff));
      out_in.quat_y   = ovq_pkg::to_q15((W+1)'(p_cs_c2_ff) + (W+1)'(p_ss_s2_ff));
      out_in.quat_z   = ovq_pkg::to_q15((W+1)'(p_sc_c2_ff) + (W+1)'(p_cc_s2_ff));
      out_in.quat_w   = ovq_pkg::to_q15((W+1)'(p_cc_c2_ff) - (W+1)'(p_sc_s2_ff));
      out_in.zero_dir = z2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cs1_ff     <= ovq_pkg::mulq(c0, s1);
         ss1_ff     <= ovq_pkg::mulq(s0, s1);
         cc1_ff     <= ovq_pkg::mulq(c0, c1);
         sc1_ff     <= ovq_pkg::mulq(s0, c1);
         s2_ff      <= s2;
         c2_ff      <= c2;
         z1_ff      <= zero;
         p_cs_s2_ff <= ovq_pkg::mulq(cs1_ff, s2_ff);
         p_ss_c2_ff <= ovq_pkg::mulq(ss1_ff, c2_ff);
         p_cs_c2_ff <= ovq_pkg::mulq(cs1_ff, c2_ff);
         p_ss_s2_ff <= ovq_pkg::mulq(ss1_ff, s2_ff);
         p_sc_c2_ff <= ovq_pkg::mulq(sc1_ff, c2_ff);
         p_cc_s2_ff <= ovq_pkg::mulq(cc1_ff, s2_ff);
         p_cc_c2_ff <= ovq_pkg::mulq(cc1_ff, c2_ff);
         p_sc_s2_ff <= ovq_pkg::mulq(sc1_ff, s2_ff);
         z2_ff      <= z1_ff;
         out_ff     <= out_in;
      end
   end

   assign d_out = out_ff;

endmodule

// ===== design/ovq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovq_checker
// port-level checks of the orientation quaternion pipe, bound to the top
// ----------------------------------------------------------------------------
`include "orientation_vector_to_quaternion_macros.svh"

module ovq_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ovq_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ovq_pkg::rsp_type  rsp_data
);

   `OVQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `OVQ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `OVQ_ASSERT_IMPLY(a_empty_takes, clock, reset, !rsp_valid, req_ready)
   `OVQ_ASSERT_IMPLY(a_drain_takes, clock, reset, rsp_ready, req_ready)

endmodule

bind orientation_vector_to_quaternion ovq_port_checker u_ovq_checker (.*);
